>>> rtl/text_line_whitespace_normalizer_top_macros.svh
// Assertion helpers for the line normaliser
`ifndef TEXT_LINE_WHITESPACE_NORMALIZER_TOP_MACROS_SVH
`define TEXT_LINE_WHITESPACE_NORMALIZER_TOP_MACROS_SVH

// condition must never hold on a clock edge outside reset
`define TLWN_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// same-cycle implication
`define TLWN_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLWN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tlwn_pkg.sv
`timescale 1ns / 1ps
package tlwn_pkg;

   // character codes
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;

   // command and result kinds
   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_END  = 1'b1;
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   localparam logic [3:0] MAX_INDENT_RESET = 4'd8;
   localparam logic [3:0] INDENT_SAT       = 4'd15;

   typedef struct packed {
      logic       command;
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // work handed from the front end to the back end: one input's burst
   typedef struct packed {
      logic [3:0] indent;    // leading spaces to emit
      logic       space;     // one inner space
      logic       cr;        // held carriage return
      logic       chr;       // visible byte present
      logic [7:0] byte_val;
      logic       eol;       // end of line
   } job_type;

   // back end status towards the top
   typedef struct packed {
      logic busy;
      logic load;
   } back_status_type;

endpackage

>>> rtl/text_line_whitespace_normalizer_top.sv
`timescale 1ns / 1ps
// Line whitespace normaliser. Text bytes enter by push/full and normalised
// characters and end-of-line marks leave by empty/pop, oldest first. The front
// end takes one byte per cycle while its job queue (QUEUE_DEPTH entries) has
// room; bytes that are only held back (indent, inner whitespace, a first CR)
// produce no job. The back end sequencer loads a job only when idle and then
// emits its results in order, stalling while the output register is full and
// not popped; it takes no new job until the last result is emitted. A visible
// byte can release up to a full indent of 15 spaces and a held CR ahead of
// itself. max_indent is written over csr_valid/csr_data, which is always ready;
// reset value 8.
`include "text_line_whitespace_normalizer_top_macros.svh"
module text_line_whitespace_normalizer_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tlwn_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output tlwn_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);

   logic                      accept;
   logic                      job_push;
   tlwn_pkg::job_type         job_wr, job_rd;
   logic                      job_full, job_empty;
   tlwn_pkg::back_status_type back_status;
   logic                      rsp_eol_shown, rsp_eol_clean, back_idle;

   assign csr_ready = 1'b1;
   assign full      = job_full;
   assign accept    = push && !job_full;

   tlwn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .accept    (accept),
      .req       (req_data),
      .job_push  (job_push),
      .job       (job_wr)
   );

   tlwn_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (accept && job_push),
      .wr_data (job_wr),
      .pop     (back_status.load),
      .rd_data (job_rd),
      .full    (job_full),
      .empty   (job_empty)
   );

   tlwn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .status    (back_status),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

   // checks
   assign rsp_eol_shown = !empty && (rsp_data.kind == tlwn_pkg::KIND_EOL);
   assign rsp_eol_clean = rsp_data.last_of_run && (rsp_data.out_byte == tlwn_pkg::CH_NUL);
   assign back_idle     = !back_status.busy && job_empty && (empty || pop);

   `TLWN_ASSERT_IMPLIES(a_eol_is_last, rsp_eol_shown, rsp_eol_clean, "bad end of line result")
   `TLWN_ASSERT_NEXT(a_idle_drains, back_idle, empty, "result appeared with no work pending")
   `TLWN_ASSERT_NEVER(a_queue_flags, job_full && job_empty, "job queue full and empty at once")
   `TLWN_ASSERT_NEVER(a_load_when_busy, back_status.load && back_status.busy, "load while busy")

endmodule

>>> rtl/tlwn_front.sv
`timescale 1ns / 1ps
module tlwn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [3:0]        csr_data,
   input  logic              accept,
   input  tlwn_pkg::req_type req,
   output logic              job_push,
   output tlwn_pkg::job_type job
);

   logic [3:0] max_indent_ff;
   logic       line_open_ff, line_open_in;
   logic       in_indent_ff, in_indent_in;
   logic [3:0] indent_count_ff, indent_count_in;
   logic       space_pending_ff, space_pending_in;
   logic       cr_pending_ff, cr_pending_in;
   logic [3:0] release_count;
   logic       is_end, is_visible, is_ws;

   // leading spaces released by a visible byte or by any non-end byte after a held CR
   always_comb begin
      if (!in_indent_ff) begin
         release_count = 4'd0;
      end else if (indent_count_ff < max_indent_ff) begin
         release_count = indent_count_ff;
      end else begin
         release_count = max_indent_ff;
      end
   end

   assign is_end = (req.text_byte == tlwn_pkg::CH_LF) || (req.text_byte == tlwn_pkg::CH_NUL);
   assign is_ws  = (req.text_byte == tlwn_pkg::CH_SP) || (req.text_byte == tlwn_pkg::CH_TAB);
   assign is_visible = !is_end && !is_ws && (req.text_byte != tlwn_pkg::CH_CR);

   // classify the byte and build its job
   always_comb begin
      line_open_in     = line_open_ff;
      in_indent_in     = in_indent_ff;
      indent_count_in  = indent_count_ff;
      space_pending_in = space_pending_ff;
      cr_pending_in    = cr_pending_ff;
      job_push         = 1'b0;
      job.indent       = release_count;
      job.space        = space_pending_ff;
      job.cr           = cr_pending_ff;
      job.chr          = 1'b0;
      job.byte_val     = req.text_byte;
      job.eol          = 1'b0;

      if ((req.command == tlwn_pkg::CMD_END) || is_end) begin
         // close the line; held whitespace and CR are dropped
         job.indent = 4'd0;
         job.space  = 1'b0;
         job.cr     = 1'b0;
         job.eol    = 1'b1;
         job_push   = (req.command == tlwn_pkg::CMD_TEXT) || line_open_ff;
         line_open_in     = 1'b0;
         in_indent_in     = 1'b1;
         indent_count_in  = 4'd0;
         space_pending_in = 1'b0;
         cr_pending_in    = 1'b0;
      end else begin
         line_open_in = 1'b1;
         if (is_visible || cr_pending_ff) begin
            // release everything held back
            job_push         = 1'b1;
            job.chr          = is_visible;
            in_indent_in     = 1'b0;
            indent_count_in  = 4'd0;
            space_pending_in = is_ws;
            cr_pending_in    = (req.text_byte == tlwn_pkg::CH_CR);
         end else if (req.text_byte == tlwn_pkg::CH_CR) begin
            cr_pending_in = 1'b1;
         end else if (in_indent_ff) begin
            if (indent_count_ff < tlwn_pkg::INDENT_SAT) begin
               indent_count_in = indent_count_ff + 4'd1;
            end
         end else begin
            space_pending_in = 1'b1;
         end
      end
   end

   // line state and the indent register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_indent_ff    <= tlwn_pkg::MAX_INDENT_RESET;
         line_open_ff     <= 1'b0;
         in_indent_ff     <= 1'b1;
         indent_count_ff  <= 4'd0;
         space_pending_ff <= 1'b0;
         cr_pending_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            max_indent_ff <= csr_data;
         end
         if (accept) begin
            line_open_ff     <= line_open_in;
            in_indent_ff     <= in_indent_in;
            indent_count_ff  <= indent_count_in;
            space_pending_ff <= space_pending_in;
            cr_pending_ff    <= cr_pending_in;
         end
      end
   end

endmodule

>>> rtl/tlwn_fifo.sv
`timescale 1ns / 1ps
module tlwn_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlwn_pkg::job_type wr_data,
   input  logic              pop,
   output tlwn_pkg::job_type rd_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tlwn_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

>>> rtl/tlwn_back.sv
`timescale 1ns / 1ps
module tlwn_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_empty,
   input  tlwn_pkg::job_type         job,
   output tlwn_pkg::back_status_type status,
   input  logic                      pop,
   output logic                      empty,
   output tlwn_pkg::rsp_type         rsp_data
);

   logic              busy_ff, busy_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              sp_ff, sp_in;
   logic              cr_ff, cr_in;
   logic              chr_ff, chr_in;
   logic              eol_ff, eol_in;
   logic [7:0]        byte_ff;
   logic              rsp_valid_ff;
   tlwn_pkg::rsp_type rsp_ff, rsp_in;
   logic              slot_free, emit, load;

   assign slot_free = !rsp_valid_ff || pop;
   assign emit      = busy_ff && slot_free;
   assign load      = !busy_ff && !job_empty;
   assign empty     = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign status.busy = busy_ff;
   assign status.load = load;

   // pick the next result of the burst in order
   always_comb begin
      cnt_in = cnt_ff;
      sp_in  = sp_ff;
      cr_in  = cr_ff;
      chr_in = chr_ff;
      eol_in = eol_ff;
      rsp_in.kind     = tlwn_pkg::KIND_CHAR;
      rsp_in.out_byte = tlwn_pkg::CH_SP;
      if (cnt_ff != 4'd0) begin
         cnt_in = cnt_ff - 4'd1;
      end else if (sp_ff) begin
         sp_in = 1'b0;
      end else if (cr_ff) begin
         cr_in = 1'b0;
         rsp_in.out_byte = tlwn_pkg::CH_CR;
      end else if (chr_ff) begin
         chr_in = 1'b0;
         rsp_in.out_byte = byte_ff;
      end else begin
         eol_in = 1'b0;
         rsp_in.kind     = tlwn_pkg::KIND_EOL;
         rsp_in.out_byte = 8'h00;
      end
      rsp_in.last_of_run = !((cnt_in != 4'd0) || sp_in || cr_in || chr_in || eol_in);
      busy_in = !rsp_in.last_of_run;
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (emit) begin
            busy_ff <= busy_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // job payload
   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff  <= job.indent;
         sp_ff   <= job.space;
         cr_ff   <= job.cr;
         chr_ff  <= job.chr;
         byte_ff <= job.byte_val;
         eol_ff  <= job.eol;
      end else if (emit) begin
         cnt_ff <= cnt_in;
         sp_ff  <= sp_in;
         cr_ff  <= cr_in;
         chr_ff <= chr_in;
         eol_ff <= eol_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
